@@ rtl/keypad_set_seconds_timer_assert.svh @@
// Assertion macros shared by the keypad seconds timer RTL.
// Needs nothing else; the bodies are empty when SYNTHESIS is defined.
`ifndef KEYPAD_SET_SECONDS_TIMER_ASSERT_SVH
`define KEYPAD_SET_SECONDS_TIMER_ASSERT_SVH
`ifndef SYNTHESIS
// The property holds at every clock edge outside reset.
`define KST_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("keypad timer assertion failed");
// When the antecedent holds, the consequent holds in the next cycle.
`define KST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keypad timer assertion failed");
`else
`define KST_ASSERT(label, clk, rst, prop)
`define KST_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/kst_pkg.sv @@
// Shared constants and types for the keypad seconds timer.
// Used by kst_entry, kst_timer and keypad_set_seconds_timer; depends on nothing.
package kst_pkg;

   localparam int SECS_W    = 14;
   localparam int DIGIT_W   = 3;
   localparam int KEY_W     = 4;
   localparam int TICKS_W   = 8;
   localparam int MAX_DIGITS = 4;

   localparam logic [KEY_W-1:0]   KEY_LAST_DIGIT = 4'd9;
   localparam logic [KEY_W-1:0]   KEY_CONFIRM    = 4'd14;
   // Previous-key code: bit 4 set means no key held.
   localparam logic [KEY_W:0]     KEY_NONE       = 5'h10;
   localparam logic [SECS_W-1:0]  SECS_MAX       = 14'h3FFF;
   localparam logic [TICKS_W-1:0] TICKS_RESET    = 8'd10;

   localparam logic KIND_KEY  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef struct packed {
      logic              load;
      logic [SECS_W-1:0] value;
   } confirm_type;

endpackage

@@ rtl/keypad_set_seconds_timer.sv @@
// Top level of the keypad seconds timer: channel registers and the
// configuration register. Depends on kst_pkg, kst_entry and kst_timer.
//
// Usage:
//  - Input channel req_*: one item per keypad sample (req_kind = 0) or
//    timer tick (req_kind = 1), taken when req_valid is high and req_stall low.
//  - Result channel rsp_*: exactly one result per item, in order, giving the
//    entry, digit count, target, elapsed seconds, running flag and done LED
//    as they stand after that item.
//  - Configuration: csr_write_enable loads csr_write_data into the ticks per
//    second register at the clock edge; write it only while no item is in
//    flight. A value of 0 makes every tick a second.
//  - Path: an accepted item waits in the input register, and its result is
//    valid once the item moves from there into the result register.
//  - Throughput: one item per cycle while no result is held by rsp_stall;
//    the entry and counter registers update as each item advances.
//  - Stall: while rsp_stall holds a result, the input register keeps its
//    item and req_stall rises only once that register is also full.
//  - Reset (synchronous, active high): both channel registers empty, entry,
//    target and counts zero, no key held, ticks per second 10.

module keypad_set_seconds_timer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_kind,
   input  logic                        req_key_down,
   input  logic [kst_pkg::KEY_W-1:0]   req_key_code,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [kst_pkg::SECS_W-1:0]  rsp_entry_value,
   output logic [kst_pkg::DIGIT_W-1:0] rsp_digits_typed,
   output logic [kst_pkg::SECS_W-1:0]  rsp_target_secs,
   output logic [kst_pkg::SECS_W-1:0]  rsp_elapsed_secs,
   output logic                        rsp_is_running,
   output logic                        rsp_done_led,
   input  logic                        csr_write_enable,
   input  logic [kst_pkg::TICKS_W-1:0] csr_write_data
);

   logic                        in_valid_ff, in_valid_in;
   logic                        in_kind_ff, in_down_ff;
   logic [kst_pkg::KEY_W-1:0]   in_code_ff;
   logic                        out_valid_ff, out_valid_in;
   logic [kst_pkg::TICKS_W-1:0] tps_ff;
   logic                        accept, advance;

   kst_pkg::confirm_type        confirm;
   logic [kst_pkg::SECS_W-1:0]  entry_in, target_in, secs_in;
   logic [kst_pkg::DIGIT_W-1:0] count_in;
   logic                        run_in, led_in;

   // The item in the input register moves on unless a result is held.
   assign advance   = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         tps_ff       <= kst_pkg::TICKS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            tps_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_kind_ff <= req_kind;
         in_down_ff <= req_key_down;
         in_code_ff <= req_key_code;
      end
      if (advance) begin
         rsp_entry_value  <= entry_in;
         rsp_digits_typed <= count_in;
         rsp_target_secs  <= target_in;
         rsp_elapsed_secs <= secs_in;
         rsp_is_running   <= run_in;
         rsp_done_led     <= led_in;
      end
   end

   kst_entry u_entry (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .kind     (in_kind_ff),
      .key_down (in_down_ff),
      .key_code (in_code_ff),
      .confirm  (confirm),
      .entry_in (entry_in),
      .count_in (count_in)
   );

   kst_timer u_timer (
      .clock            (clock),
      .reset            (reset),
      .step             (advance),
      .kind             (in_kind_ff),
      .confirm          (confirm),
      .ticks_per_second (tps_ff),
      .target_in        (target_in),
      .secs_in          (secs_in),
      .run_in           (run_in),
      .led_in           (led_in)
   );

endmodule

@@ rtl/kst_entry.sv @@
// Keypad entry: edge detection of key presses and the decimal digit entry.
// Depends on kst_pkg and the assertion macro header.
`include "keypad_set_seconds_timer_assert.svh"

module kst_entry (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        kind,
   input  logic                        key_down,
   input  logic [kst_pkg::KEY_W-1:0]   key_code,
   output kst_pkg::confirm_type        confirm,
   output logic [kst_pkg::SECS_W-1:0]  entry_in,
   output logic [kst_pkg::DIGIT_W-1:0] count_in
);

   logic [kst_pkg::KEY_W:0]     prev_key_ff, prev_key_in;
   logic [kst_pkg::SECS_W-1:0]  entry_ff;
   logic [kst_pkg::DIGIT_W-1:0] count_ff;
   logic [kst_pkg::SECS_W+3:0]  appended;
   logic [kst_pkg::KEY_W:0]     code_ext;

   assign code_ext = {1'b0, key_code};
   // entry * 10 + digit, wide enough never to wrap.
   assign appended = {1'b0, entry_ff, 3'b000} + {3'b000, entry_ff, 1'b0}
                     + {{(kst_pkg::SECS_W){1'b0}}, key_code};

   always_comb begin
      prev_key_in   = prev_key_ff;
      entry_in      = entry_ff;
      count_in      = count_ff;
      confirm.load  = 1'b0;
      confirm.value = entry_ff;
      if (step && (kind == kst_pkg::KIND_KEY)) begin
         if (!key_down) begin
            prev_key_in = kst_pkg::KEY_NONE;
         end else if (code_ext != prev_key_ff) begin
            prev_key_in = code_ext;
            if (key_code <= kst_pkg::KEY_LAST_DIGIT) begin
               if (count_ff < kst_pkg::DIGIT_W'(kst_pkg::MAX_DIGITS)) begin
                  if (appended > {4'b0000, kst_pkg::SECS_MAX}) begin
                     entry_in = kst_pkg::SECS_MAX;
                  end else begin
                     entry_in = appended[kst_pkg::SECS_W-1:0];
                  end
                  count_in = count_ff + kst_pkg::DIGIT_W'(1);
               end
            end else if (key_code == kst_pkg::KEY_CONFIRM) begin
               confirm.load = 1'b1;
               entry_in     = '0;
               count_in     = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_key_ff <= kst_pkg::KEY_NONE;
         entry_ff    <= '0;
         count_ff    <= '0;
      end else begin
         prev_key_ff <= prev_key_in;
         entry_ff    <= entry_in;
         count_ff    <= count_in;
      end
   end

   `KST_ASSERT(a_count_limit, clock, reset,
      count_ff <= kst_pkg::DIGIT_W'(kst_pkg::MAX_DIGITS))
   `KST_ASSERT_NEXT(a_held_key, clock, reset,
      step && (kind == kst_pkg::KIND_KEY) && key_down && (code_ext == prev_key_ff),
      $stable(entry_ff) && $stable(count_ff) && $stable(prev_key_ff))

endmodule

@@ rtl/kst_timer.sv @@
// Seconds counter: target load, tick prescaler, elapsed count and done LED.
// Depends on kst_pkg and the assertion macro header.
`include "keypad_set_seconds_timer_assert.svh"

module kst_timer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        kind,
   input  kst_pkg::confirm_type        confirm,
   input  logic [kst_pkg::TICKS_W-1:0] ticks_per_second,
   output logic [kst_pkg::SECS_W-1:0]  target_in,
   output logic [kst_pkg::SECS_W-1:0]  secs_in,
   output logic                        run_in,
   output logic                        led_in
);

   logic [kst_pkg::SECS_W-1:0]  target_ff;
   logic [kst_pkg::SECS_W-1:0]  secs_ff;
   logic [kst_pkg::TICKS_W-1:0] prescale_ff, prescale_in, prescale_inc;
   logic                        run_ff, led_ff;

   assign prescale_inc = prescale_ff + kst_pkg::TICKS_W'(1);

   always_comb begin
      target_in   = target_ff;
      secs_in     = secs_ff;
      prescale_in = prescale_ff;
      run_in      = run_ff;
      led_in      = led_ff;
      if (step) begin
         if (confirm.load) begin
            target_in = confirm.value;
            secs_in   = '0;
            run_in    = 1'b1;
            led_in    = 1'b0;
         end else if ((kind == kst_pkg::KIND_TICK) && run_ff) begin
            if (prescale_inc >= ticks_per_second) begin
               prescale_in = '0;
               if (secs_ff != kst_pkg::SECS_MAX) begin
                  secs_in = secs_ff + kst_pkg::SECS_W'(1);
               end
            end else begin
               prescale_in = prescale_inc;
            end
         end
         // The finish check sees the values left by this item.
         if (run_in && (secs_in >= target_in)) begin
            run_in = 1'b0;
            led_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= '0;
         secs_ff     <= '0;
         prescale_ff <= '0;
         run_ff      <= 1'b0;
         led_ff      <= 1'b0;
      end else begin
         target_ff   <= target_in;
         secs_ff     <= secs_in;
         prescale_ff <= prescale_in;
         run_ff      <= run_in;
         led_ff      <= led_in;
      end
   end

   `KST_ASSERT(a_run_led_exclusive, clock, reset, !(run_ff && led_ff))
   `KST_ASSERT_NEXT(a_confirm_loads, clock, reset, step && confirm.load,
      (target_ff == $past(confirm.value)) && (secs_ff == '0))

endmodule

@@ tb/tb_keypad_set_seconds_timer.sv @@
// Self-checking testbench for keypad_set_seconds_timer: keypad samples and ticks go in,
// and each status result is checked against an in-bench model of the entry and the timer.
// Depends on kst_pkg and the keypad_set_seconds_timer RTL.
module tb_keypad_set_seconds_timer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT       = 600000;
   localparam int unsigned LONG_HOLD_CYCLES  = 70;
   localparam int unsigned SETTLE_CYCLES     = 4;
   localparam logic [kst_pkg::KEY_W-1:0] KEY_SPARE = 4'd15;

   typedef struct packed {
      logic [kst_pkg::SECS_W-1:0]  entry_value;
      logic [kst_pkg::DIGIT_W-1:0] digits_typed;
      logic [kst_pkg::SECS_W-1:0]  target_secs;
      logic [kst_pkg::SECS_W-1:0]  elapsed_secs;
      logic                        is_running;
      logic                        done_led;
   } timer_status_type;

   class timer_scoreboard;
      timer_status_type            status_q[$];
      int unsigned                 errors;
      logic [kst_pkg::KEY_W:0]     held_key;
      logic [kst_pkg::SECS_W-1:0]  entry;
      logic [kst_pkg::DIGIT_W-1:0] digit_count;
      logic [kst_pkg::SECS_W-1:0]  target;
      logic [kst_pkg::SECS_W-1:0]  elapsed;
      logic [kst_pkg::TICKS_W-1:0] prescale;
      logic [kst_pkg::TICKS_W-1:0] ticks_per_sec;
      logic                        running;
      logic                        led;

      function new();
         errors        = 0;
         held_key      = kst_pkg::KEY_NONE;
         entry         = '0;
         digit_count   = '0;
         target        = '0;
         elapsed       = '0;
         prescale      = '0;
         ticks_per_sec = kst_pkg::TICKS_RESET;
         running       = 1'b0;
         led           = 1'b0;
      endfunction

      function void set_ticks(logic [kst_pkg::TICKS_W-1:0] value);
         ticks_per_sec = value;
      endfunction

      function int unsigned pending();
         return status_q.size();
      endfunction

      // Advances the model by one accepted item and queues the status it leads to.
      function void note_item(logic kind, logic down, logic [kst_pkg::KEY_W-1:0] code);
         int unsigned      sum;
         timer_status_type status;
         if (kind == kst_pkg::KIND_KEY) begin
            if (!down) begin
               held_key = kst_pkg::KEY_NONE;
            end else if ({1'b0, code} != held_key) begin
               held_key = {1'b0, code};
               if (code <= kst_pkg::KEY_LAST_DIGIT) begin
                  if (digit_count < kst_pkg::MAX_DIGITS) begin
                     sum = entry * 10 + code;
                     entry = (sum > kst_pkg::SECS_MAX) ? kst_pkg::SECS_MAX
                                                       : sum[kst_pkg::SECS_W-1:0];
                     digit_count++;
                  end
               end else if (code == kst_pkg::KEY_CONFIRM) begin
                  target      = entry;
                  entry       = '0;
                  digit_count = '0;
                  elapsed     = '0;
                  running     = 1'b1;
                  led         = 1'b0;
               end
            end
         end else if (running) begin
            prescale = prescale + kst_pkg::TICKS_W'(1);
            if (prescale >= ticks_per_sec) begin
               prescale = '0;
               if (elapsed < kst_pkg::SECS_MAX)
                  elapsed++;
            end
         end
         if (running && elapsed >= target) begin
            running = 1'b0;
            led     = 1'b1;
         end
         status.entry_value  = entry;
         status.digits_typed = digit_count;
         status.target_secs  = target;
         status.elapsed_secs = elapsed;
         status.is_running   = running;
         status.done_led     = led;
         status_q.push_back(status);
      endfunction

      task report_mismatch(string field, int unsigned got, int unsigned want);
         $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, field, got, want);
         errors++;
      endtask

      task check_result(timer_status_type got);
         timer_status_type want;
         if (status_q.size() == 0) begin
            report_mismatch("result with nothing expected", 0, 0);
            return;
         end
         want = status_q.pop_front();
         if (got.entry_value !== want.entry_value)
            report_mismatch("entry_value", 32'(got.entry_value), 32'(want.entry_value));
         if (got.digits_typed !== want.digits_typed)
            report_mismatch("digits_typed", 32'(got.digits_typed), 32'(want.digits_typed));
         if (got.target_secs !== want.target_secs)
            report_mismatch("target_secs", 32'(got.target_secs), 32'(want.target_secs));
         if (got.elapsed_secs !== want.elapsed_secs)
            report_mismatch("elapsed_secs", 32'(got.elapsed_secs), 32'(want.elapsed_secs));
         if (got.is_running !== want.is_running)
            report_mismatch("is_running", 32'(got.is_running), 32'(want.is_running));
         if (got.done_led !== want.done_led)
            report_mismatch("done_led", 32'(got.done_led), 32'(want.done_led));
      endtask
   endclass

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic                        req_kind;
   logic                        req_key_down;
   logic [kst_pkg::KEY_W-1:0]   req_key_code;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [kst_pkg::SECS_W-1:0]  rsp_entry_value;
   logic [kst_pkg::DIGIT_W-1:0] rsp_digits_typed;
   logic [kst_pkg::SECS_W-1:0]  rsp_target_secs;
   logic [kst_pkg::SECS_W-1:0]  rsp_elapsed_secs;
   logic                        rsp_is_running;
   logic                        rsp_done_led;
   logic                        csr_write_enable;
   logic [kst_pkg::TICKS_W-1:0] csr_write_data;

   timer_scoreboard             sb = new();
   int unsigned                 cycle_count = 0;
   int unsigned                 items_sent = 0;
   logic [kst_pkg::TICKS_W-1:0] cur_ticks = kst_pkg::TICKS_RESET;
   bit                          tx_quiet = 1'b0;
   bit                          rx_quiet = 1'b0;
   bit                          long_hold_req = 1'b0;

   keypad_set_seconds_timer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_key_down     (req_key_down),
      .req_key_code     (req_key_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_entry_value  (rsp_entry_value),
      .rsp_digits_typed (rsp_digits_typed),
      .rsp_target_secs  (rsp_target_secs),
      .rsp_elapsed_secs (rsp_elapsed_secs),
      .rsp_is_running   (rsp_is_running),
      .rsp_done_led     (rsp_done_led),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_result('{rsp_entry_value, rsp_digits_typed, rsp_target_secs,
                           rsp_elapsed_secs, rsp_is_running, rsp_done_led});
   end

   // Result side: a random hold before each item, with an occasional long hold that
   // lets the block fill up and push back on its input.
   initial begin : result_receiver
      int unsigned hold;
      rsp_stall = 1'b0;
      @(posedge clock);
      @(negedge clock);
      forever begin
         hold = rx_quiet ? 0 : $urandom_range(0, 19);
         if (long_hold_req) begin
            hold += LONG_HOLD_CYCLES;
            long_hold_req = 1'b0;
         end
         if ($urandom_range(0, 39) == 0)
            rx_quiet = !rx_quiet;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
         @(negedge clock);
      end
   end

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task send_item(logic kind, logic down, logic [kst_pkg::KEY_W-1:0] code);
      int unsigned gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 39) == 0)
         tx_quiet = !tx_quiet;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_key_down <= down;
      req_key_code <= code;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_item(kind, down, code);
      items_sent++;
      @(negedge clock);
   endtask

   task send_tick();
      send_item(kst_pkg::KIND_TICK, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
   endtask

   // A key press, sometimes seen twice while held, and usually released afterwards.
   task press_key(logic [kst_pkg::KEY_W-1:0] code);
      send_item(kst_pkg::KIND_KEY, 1'b1, code);
      if ($urandom_range(0, 3) == 0)
         send_item(kst_pkg::KIND_KEY, 1'b1, code);
      if ($urandom_range(0, 7) != 0)
         send_item(kst_pkg::KIND_KEY, 1'b0, 4'($urandom_range(0, 15)));
   endtask

   task drain_results();
      req_valid <= 1'b0;
      while (sb.pending() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task write_ticks(logic [kst_pkg::TICKS_W-1:0] value);
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.set_ticks(value);
      cur_ticks = value;
   endtask

   // Mostly a full timer run: type an entry, confirm, then feed ticks; the rest is noise.
   task run_sequence();
      int unsigned choice;
      int unsigned digits;
      int unsigned span;
      int unsigned ticks;
      choice = $urandom_range(0, 99);
      if (choice < 12) begin
         send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   4'($urandom_range(0, 15)));
      end else if (choice < 22) begin
         repeat ($urandom_range(1, 8)) send_tick();
      end else if (choice < 30) begin
         press_key(4'($urandom_range(0, 15)));
      end else begin
         choice = $urandom_range(0, 9);
         digits = (choice < 2) ? 0 : (choice < 7) ? 1 : (choice < 9) ? 2 : $urandom_range(3, 6);
         repeat (digits) press_key(4'($urandom_range(0, 9)));
         if ($urandom_range(0, 9) != 0)
            press_key(kst_pkg::KEY_CONFIRM);
         span  = (cur_ticks == 0) ? 1 : cur_ticks;
         span  = span * 6 + 2;
         ticks = $urandom_range(1, (span > 270) ? 270 : span);
         repeat (ticks) send_tick();
      end
   endtask

   task run_phase(int unsigned budget);
      int unsigned start;
      start = items_sent;
      while (items_sent - start < budget)
         run_sequence();
   endtask

   initial begin : stimulus
      logic [kst_pkg::KEY_W-1:0] code;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_kind         = kst_pkg::KIND_KEY;
      req_key_down     = 1'b0;
      req_key_code     = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: stopped tick, empty confirm, held keys, a full entry of nines,
      // ignored codes, and digits and a restart while running.
      send_item(kst_pkg::KIND_TICK, 1'b1, KEY_SPARE);
      send_item(kst_pkg::KIND_KEY, 1'b0, 4'd0);
      send_item(kst_pkg::KIND_KEY, 1'b1, kst_pkg::KEY_CONFIRM);
      send_item(kst_pkg::KIND_KEY, 1'b1, kst_pkg::KEY_CONFIRM);
      send_item(kst_pkg::KIND_KEY, 1'b0, KEY_SPARE);
      repeat (3) begin
         send_item(kst_pkg::KIND_KEY, 1'b1, kst_pkg::KEY_LAST_DIGIT);
         send_item(kst_pkg::KIND_KEY, 1'b0, kst_pkg::KEY_LAST_DIGIT);
      end
      send_item(kst_pkg::KIND_KEY, 1'b1, kst_pkg::KEY_LAST_DIGIT);
      send_item(kst_pkg::KIND_KEY, 1'b1, 4'd5);
      for (code = kst_pkg::KEY_LAST_DIGIT + 4'd1; code < kst_pkg::KEY_CONFIRM; code++)
         send_item(kst_pkg::KIND_KEY, 1'b1, code);
      send_item(kst_pkg::KIND_KEY, 1'b1, KEY_SPARE);
      send_item(kst_pkg::KIND_KEY, 1'b1, kst_pkg::KEY_CONFIRM);
      send_item(kst_pkg::KIND_TICK, 1'b0, 4'd0);
      send_item(kst_pkg::KIND_KEY, 1'b1, 4'd0);
      send_item(kst_pkg::KIND_KEY, 1'b0, 4'd0);
      send_item(kst_pkg::KIND_KEY, 1'b1, kst_pkg::KEY_CONFIRM);
      send_item(kst_pkg::KIND_TICK, 1'b1, 4'd0);

      run_phase(250);
      drain_results();
      write_ticks(8'd1);
      run_phase(120);
      // Let the result side hold off while items keep coming, then pause until all is back.
      long_hold_req = 1'b1;
      tx_quiet      = 1'b1;
      run_phase(60);
      drain_results();
      run_phase(120);
      drain_results();
      write_ticks(8'd255);
      run_phase(200);
      drain_results();
      write_ticks(8'd0);
      run_phase(150);
      drain_results();
      write_ticks(8'($urandom_range(2, 12)));
      run_phase(250);
      drain_results();
      write_ticks(8'd3);
      long_hold_req = 1'b1;
      run_phase(150);

      drain_results();
      repeat (10) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ keypad_set_seconds_timer.f @@
+incdir+rtl
rtl/kst_pkg.sv
rtl/kst_entry.sv
rtl/kst_timer.sv
rtl/keypad_set_seconds_timer.sv
tb/tb_keypad_set_seconds_timer.sv
